[hdl/lpi_pkg.sv]
package lpi_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIELD_BITS     = 16;
  localparam int OUT_BITS       = 48;
  localparam int QUEUE_DEPTH    = 4;

  typedef enum logic [1:0] {
    REL_POINT    = 2'd0,
    REL_SAME     = 2'd1,
    REL_PARALLEL = 2'd2
  } rel_t;

  // Status of the queue between the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Packed item: relation, a1x, a1y, dax, day, den, num.
  function automatic int item_width(input int coord_bits);
    return 2 + 2 * coord_bits + 2 * (coord_bits + 1) + 2 * (2 * coord_bits + 3);
  endfunction

endpackage

[hdl/lpi_front.sv]
module lpi_front import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [FIELD_BITS-1:0]         in_ax_first,
  input  logic signed [FIELD_BITS-1:0]         in_ay_first,
  input  logic signed [FIELD_BITS-1:0]         in_ax_second,
  input  logic signed [FIELD_BITS-1:0]         in_ay_second,
  input  logic signed [FIELD_BITS-1:0]         in_bx_first,
  input  logic signed [FIELD_BITS-1:0]         in_by_first,
  input  logic signed [FIELD_BITS-1:0]         in_bx_second,
  input  logic signed [FIELD_BITS-1:0]         in_by_second,
  input  qstat_t                               qstat,
  output logic                                 push,
  output logic [item_width(COORD_BITS)-1:0]    item
);

  localparam int C  = COORD_BITS;
  localparam int D1 = C + 1;
  localparam int P  = 2 * C + 2;
  localparam int DW = 2 * C + 3;
  localparam int CR = (C > FIELD_BITS) ? C : FIELD_BITS;

  // Only the low C bits of a field count; a narrow field is zero-extended first.
  function automatic logic signed [C-1:0] crd(input logic [FIELD_BITS-1:0] v);
    logic [CR-1:0] t;
    t = CR'(v);
    return t[C-1:0];
  endfunction

  logic en;
  logic s1_v_r, s2_v_r, s3_v_r;

  logic signed [C-1:0]  s1_a1x_r, s1_a1y_r;
  logic signed [D1-1:0] s1_dax_r, s1_day_r, s1_dbx_r, s1_dby_r, s1_wx_r, s1_wy_r;

  logic signed [C-1:0]  s2_a1x_r, s2_a1y_r;
  logic signed [D1-1:0] s2_dax_r, s2_day_r;
  logic signed [P-1:0]  s2_p0_r, s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r, s2_p5_r;

  logic signed [C-1:0]  a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
  logic signed [DW-1:0] den_nxt, num_nxt, ca_nxt;
  rel_t                 rel_nxt;
  logic [item_width(COORD_BITS)-1:0] item_r;

  assign en       = !(s3_v_r && qstat.full);
  assign in_stall = !en;
  assign push     = s3_v_r && !qstat.full;
  assign item     = item_r;

  assign a1x = crd(in_ax_first);
  assign a1y = crd(in_ay_first);
  assign a2x = crd(in_ax_second);
  assign a2y = crd(in_ay_second);
  assign b1x = crd(in_bx_first);
  assign b1y = crd(in_by_first);
  assign b2x = crd(in_bx_second);
  assign b2y = crd(in_by_second);

  always_comb begin
    den_nxt = DW'(s2_p0_r) - DW'(s2_p1_r);
    num_nxt = DW'(s2_p2_r) - DW'(s2_p3_r);
    ca_nxt  = DW'(s2_p4_r) - DW'(s2_p5_r);
    if (den_nxt != '0) begin
      rel_nxt = REL_POINT;
    end else if (ca_nxt == '0 && num_nxt == '0) begin
      rel_nxt = REL_SAME;
    end else begin
      rel_nxt = REL_PARALLEL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a1x_r <= a1x;
      s1_a1y_r <= a1y;
      s1_dax_r <= D1'(a2x) - D1'(a1x);
      s1_day_r <= D1'(a2y) - D1'(a1y);
      s1_dbx_r <= D1'(b2x) - D1'(b1x);
      s1_dby_r <= D1'(b2y) - D1'(b1y);
      s1_wx_r  <= D1'(b1x) - D1'(a1x);
      s1_wy_r  <= D1'(b1y) - D1'(a1y);

      s2_a1x_r <= s1_a1x_r;
      s2_a1y_r <= s1_a1y_r;
      s2_dax_r <= s1_dax_r;
      s2_day_r <= s1_day_r;
      s2_p0_r  <= s1_dax_r * s1_dby_r;
      s2_p1_r  <= s1_day_r * s1_dbx_r;
      s2_p2_r  <= s1_wx_r * s1_dby_r;
      s2_p3_r  <= s1_wy_r * s1_dbx_r;
      s2_p4_r  <= s1_wx_r * s1_day_r;
      s2_p5_r  <= s1_wy_r * s1_dax_r;

      item_r <= {rel_nxt, s2_a1x_r, s2_a1y_r, s2_dax_r, s2_day_r, den_nxt, num_nxt};
    end
  end

endmodule

[hdl/lpi_fifo.sv]
module lpi_fifo import lpi_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output qstat_t       qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [W-1:0]  rdata_r;
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // The popped entry appears on rdata in the cycle after the pop.
  assign rdata       = rdata_r;
  assign qstat.full  = (cnt_r == CW'(DEPTH));
  assign qstat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= bump(wr_r);
      if (pop)  rd_r <= bump(rd_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= wdata;
    if (pop)  rdata_r <= mem_r[rd_r];
  end

endmodule

[hdl/lpi_back.sv]
module lpi_back import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  qstat_t                            qstat,
  input  logic [item_width(COORD_BITS)-1:0] item,
  output logic                              pop,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [1:0]                        out_relation,
  output logic signed [OUT_BITS-1:0]        out_meet_x,
  output logic signed [OUT_BITS-1:0]        out_meet_y,
  output logic                              out_saturated
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = 2 * C + 3;
  localparam int L    = DW / 2;
  localparam int H    = DW - L;
  localparam int NW   = 3 * C + 4;
  localparam int NB   = NW + F + 1;
  localparam int QW   = (NB > OUT_BITS) ? NB : OUT_BITS + 1;
  localparam int WA_L = C + L + 1;
  localparam int WA_H = C + H;
  localparam int WB_L = C + L + 2;
  localparam int WB_H = C + 1 + H;

  logic en;

  // Unpacked queue head.
  logic [1:0]           h_rel;
  logic signed [C-1:0]  h_a1x, h_a1y;
  logic signed [C:0]    h_dax, h_day;
  logic signed [DW-1:0] h_den, h_num;
  logic signed [H-1:0]  den_hi, num_hi;
  logic [L-1:0]         den_lo, num_lo;

  assign {h_rel, h_a1x, h_a1y, h_dax, h_day, h_den, h_num} = item;
  assign den_hi = h_den[DW-1:L];
  assign den_lo = h_den[L-1:0];
  assign num_hi = h_num[DW-1:L];
  assign num_lo = h_num[L-1:0];

  assign en  = !(out_valid && out_stall);
  assign pop = en && !qstat.empty;

  // Queue read; the head is on item in the cycle after the pop.
  logic                   b0_v_r;

  // Partial products.
  logic                   b1_v_r;
  logic [1:0]             b1_rel_r;
  logic signed [DW-1:0]   b1_den_r;
  logic signed [WA_L-1:0] b1_xal_r, b1_yal_r;
  logic signed [WA_H-1:0] b1_xah_r, b1_yah_r;
  logic signed [WB_L-1:0] b1_xbl_r, b1_ybl_r;
  logic signed [WB_H-1:0] b1_xbh_r, b1_ybh_r;

  // Full numerators.
  logic                 b2_v_r;
  logic [1:0]           b2_rel_r;
  logic signed [DW-1:0] b2_den_r;
  logic signed [NW-1:0] b2_nx_r, b2_ny_r;

  // Divider pipeline; index 0 is the prepared operand, index NB the quotient.
  logic          dv_v_r   [NB+1];
  logic [1:0]    dv_rel_r [NB+1];
  logic          dv_ngx_r [NB+1];
  logic          dv_ngy_r [NB+1];
  logic [DW:0]   dv_d_r   [NB+1];
  logic [DW:0]   dv_rx_r  [NB+1];
  logic [DW:0]   dv_ry_r  [NB+1];
  logic [NB-1:0] dv_qx_r  [NB+1];
  logic [NB-1:0] dv_qy_r  [NB+1];

  logic [NW-1:0] mx_nxt, my_nxt;
  logic [DW-1:0] dm_nxt;

  always_comb begin
    mx_nxt = b2_nx_r[NW-1] ? NW'(-b2_nx_r) : NW'(b2_nx_r);
    my_nxt = b2_ny_r[NW-1] ? NW'(-b2_ny_r) : NW'(b2_ny_r);
    dm_nxt = b2_den_r[DW-1] ? DW'(-b2_den_r) : DW'(b2_den_r);
  end

  // One restoring step: shift the next numerator bit in, subtract when it fits.
  function automatic logic [DW+NB:0] div_step(input logic [DW:0] rem,
                                              input logic [NB-1:0] nq,
                                              input logic [DW:0] d2);
    logic [DW+1:0] t;
    logic [DW:0]   r;
    logic          b;
    t = {rem, nq[NB-1]};
    b = (t >= {1'b0, d2});
    r = b ? (DW+1)'(t - {1'b0, d2}) : t[DW:0];
    return {r, nq[NB-2:0], b};
  endfunction

  // Sign and clamp; top bit of the result is the saturation flag.
  function automatic logic [OUT_BITS:0] fix_out(input logic [NB-1:0] q, input logic neg);
    logic [QW-1:0] qe, lim, mag;
    logic          sat;
    qe  = QW'(q);
    lim = (QW'(1) << (OUT_BITS - 1)) - QW'(1);
    mag = qe;
    sat = 1'b0;
    if (neg) begin
      if (qe > lim + QW'(1)) begin
        mag = lim + QW'(1);
        sat = 1'b1;
      end
      mag = -mag;
    end else if (qe > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return {sat, mag[OUT_BITS-1:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r    <= 1'b0;
      b1_v_r    <= 1'b0;
      b2_v_r    <= 1'b0;
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      b0_v_r    <= pop;
      b1_v_r    <= b0_v_r;
      b2_v_r    <= b1_v_r;
      dv_v_r[0] <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_rel_r <= h_rel;
      b1_den_r <= h_den;
      b1_xal_r <= h_a1x * $signed({1'b0, den_lo});
      b1_xah_r <= h_a1x * den_hi;
      b1_yal_r <= h_a1y * $signed({1'b0, den_lo});
      b1_yah_r <= h_a1y * den_hi;
      b1_xbl_r <= h_dax * $signed({1'b0, num_lo});
      b1_xbh_r <= h_dax * num_hi;
      b1_ybl_r <= h_day * $signed({1'b0, num_lo});
      b1_ybh_r <= h_day * num_hi;

      b2_rel_r <= b1_rel_r;
      b2_den_r <= b1_den_r;
      b2_nx_r  <= NW'(b1_xal_r) + (NW'(b1_xah_r) <<< L)
                + NW'(b1_xbl_r) + (NW'(b1_xbh_r) <<< L);
      b2_ny_r  <= NW'(b1_yal_r) + (NW'(b1_yah_r) <<< L)
                + NW'(b1_ybl_r) + (NW'(b1_ybh_r) <<< L);

      // Rounded quotient is (2m + d) / 2d with m the scaled magnitude.
      dv_rel_r[0] <= b2_rel_r;
      dv_ngx_r[0] <= b2_nx_r[NW-1] ^ b2_den_r[DW-1];
      dv_ngy_r[0] <= b2_ny_r[NW-1] ^ b2_den_r[DW-1];
      dv_d_r[0]   <= {dm_nxt, 1'b0};
      dv_rx_r[0]  <= '0;
      dv_ry_r[0]  <= '0;
      dv_qx_r[0]  <= (NB'(mx_nxt) << (F + 1)) + NB'(dm_nxt);
      dv_qy_r[0]  <= (NB'(my_nxt) << (F + 1)) + NB'(dm_nxt);
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_div
    logic [DW+NB:0] sx, sy;
    assign sx = div_step(dv_rx_r[k], dv_qx_r[k], dv_d_r[k]);
    assign sy = div_step(dv_ry_r[k], dv_qy_r[k], dv_d_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rel_r[k+1] <= dv_rel_r[k];
        dv_ngx_r[k+1] <= dv_ngx_r[k];
        dv_ngy_r[k+1] <= dv_ngy_r[k];
        dv_d_r[k+1]   <= dv_d_r[k];
        {dv_rx_r[k+1], dv_qx_r[k+1]} <= sx;
        {dv_ry_r[k+1], dv_qy_r[k+1]} <= sy;
      end
    end
  end

  logic [OUT_BITS:0] fx_nxt, fy_nxt;
  logic              out_valid_r, sat_r;
  logic [1:0]        rel_r;
  logic [OUT_BITS-1:0] mx_r, my_r;

  assign fx_nxt = fix_out(dv_qx_r[NB], dv_ngx_r[NB]);
  assign fy_nxt = fix_out(dv_qy_r[NB], dv_ngy_r[NB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel_r <= dv_rel_r[NB];
      if (rel_t'(dv_rel_r[NB]) == REL_POINT) begin
        mx_r  <= fx_nxt[OUT_BITS-1:0];
        my_r  <= fy_nxt[OUT_BITS-1:0];
        sat_r <= fx_nxt[OUT_BITS] | fy_nxt[OUT_BITS];
      end else begin
        mx_r  <= '0;
        my_r  <= '0;
        sat_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_relation  = rel_r;
  assign out_meet_x    = mx_r;
  assign out_meet_y    = my_r;
  assign out_saturated = sat_r;

endmodule

[hdl/line_pair_intersection.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_stall  | two points of line A, two points of line B
// result   | out_valid / out_stall| relation, meet_x, meet_y, saturated
//
// One line pair is taken per cycle while in_stall is low, one result leaves
// per cycle while out_stall is low. A pair runs through the front stages, the
// queue and the back stages, most of them the one-bit-per-stage divider.
// Reset is synchronous and active low; it empties every stage and the queue.
// A stalled result holds the back part only; the front keeps filling the queue
// and stalls the input once the queue is full and its last stage is occupied.
module line_pair_intersection import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [FIELD_BITS-1:0]  in_ax_first,
  input  logic signed [FIELD_BITS-1:0]  in_ay_first,
  input  logic signed [FIELD_BITS-1:0]  in_ax_second,
  input  logic signed [FIELD_BITS-1:0]  in_ay_second,
  input  logic signed [FIELD_BITS-1:0]  in_bx_first,
  input  logic signed [FIELD_BITS-1:0]  in_by_first,
  input  logic signed [FIELD_BITS-1:0]  in_bx_second,
  input  logic signed [FIELD_BITS-1:0]  in_by_second,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_relation,
  output logic signed [OUT_BITS-1:0]    out_meet_x,
  output logic signed [OUT_BITS-1:0]    out_meet_y,
  output logic                          out_saturated
);

  localparam int IW = item_width(COORD_BITS);

  // The front works out the direction cross product and classifies the pair;
  // each transfer into the queue carries the operands the back part needs.
  qstat_t        qstat;
  logic          push, pop;
  logic [IW-1:0] f_item, q_item;

  lpi_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ax_first  (in_ax_first),
    .in_ay_first  (in_ay_first),
    .in_ax_second (in_ax_second),
    .in_ay_second (in_ay_second),
    .in_bx_first  (in_bx_first),
    .in_by_first  (in_by_first),
    .in_bx_second (in_bx_second),
    .in_by_second (in_by_second),
    .qstat        (qstat),
    .push         (push),
    .item         (f_item)
  );

  lpi_fifo #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_item),
    .pop   (pop),
    .rdata (q_item),
    .qstat (qstat)
  );

  // The back part forms the exact numerators, divides with rounding to nearest
  // and clamps to the 48-bit result range.
  lpi_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .qstat         (qstat),
    .item          (q_item),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_relation  (out_relation),
    .out_meet_x    (out_meet_x),
    .out_meet_y    (out_meet_y),
    .out_saturated (out_saturated)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import lpi_pkg::*;

  // One line pair as presented on the input channel.
  typedef struct {
    logic signed [FIELD_BITS-1:0] ax1, ay1, ax2, ay2;
    logic signed [FIELD_BITS-1:0] bx1, by1, bx2, by2;
  } line_pair_t;

  // One meeting result as it should leave the result channel.
  typedef struct {
    rel_t                       relation;
    logic signed [OUT_BITS-1:0] meet_x;
    logic signed [OUT_BITS-1:0] meet_y;
    logic                       saturated;
  } meeting_t;

  localparam int TOTAL_PAIRS = 1950;
  localparam int PHASE_LEN   = 650;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [FIELD_BITS-1:0] in_ax_first = '0, in_ay_first = '0;
  logic signed [FIELD_BITS-1:0] in_ax_second = '0, in_ay_second = '0;
  logic signed [FIELD_BITS-1:0] in_bx_first = '0, in_by_first = '0;
  logic signed [FIELD_BITS-1:0] in_bx_second = '0, in_by_second = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_relation;
  logic signed [OUT_BITS-1:0] out_meet_x, out_meet_y;
  logic out_saturated;

  line_pair_t pending_pairs[$];
  meeting_t   expected_meetings[$];
  int         pairs_sent = 0;
  int         quiet_cycles = 0;
  bit         failed = 1'b0;
  bit         stimulus_done = 1'b0;

  always #5 clk = ~clk;

  line_pair_intersection i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ax_first(in_ax_first), .in_ay_first(in_ay_first),
    .in_ax_second(in_ax_second), .in_ay_second(in_ay_second),
    .in_bx_first(in_bx_first), .in_by_first(in_by_first),
    .in_bx_second(in_bx_second), .in_by_second(in_by_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_relation(out_relation), .out_meet_x(out_meet_x),
    .out_meet_y(out_meet_y), .out_saturated(out_saturated)
  );

  // Divides the exact numerator, scaled by 2^16, by the denominator and rounds
  // to nearest with ties away from zero. The magnitude is formed first, so the
  // rounding is symmetric about zero, and then clamped to the 48-bit range.
  function automatic logic [OUT_BITS-1:0] round_to_fixed(
      input logic signed [127:0] numer, input logic signed [63:0] denom,
      inout logic clamped);
    logic         negative;
    logic [127:0] mag_n, mag_d, quot;
    logic [127:0] lim_pos;
    negative = (numer < 0) ^ (denom < 0);
    mag_n    = numer < 0 ? $unsigned(-numer) : $unsigned(numer);
    mag_d    = denom < 0 ? 128'($unsigned(-denom)) : 128'($unsigned(denom));
    mag_n    = mag_n << FRAC_BITS_DEF;
    quot     = (2 * mag_n + mag_d) / (2 * mag_d);
    lim_pos  = (128'd1 << (OUT_BITS - 1)) - 1;
    if (negative) begin
      if (quot > lim_pos + 1) begin
        quot    = lim_pos + 1;
        clamped = 1'b1;
      end
      quot = -quot;
    end else if (quot > lim_pos) begin
      quot    = lim_pos;
      clamped = 1'b1;
    end
    return quot[OUT_BITS-1:0];
  endfunction

  // Works out the relation of the two lines and, where they cross, the point.
  // The direction cross product decides parallelism; when it is zero the two
  // collinearity tests separate one shared line from two distinct ones.
  function automatic meeting_t predict_meeting(input line_pair_t p);
    meeting_t r;
    logic signed [63:0] dax, day, dbx, dby, wx, wy, den, num, side_a, side_b;
    logic signed [127:0] nx, ny;
    logic clamped;
    dax = 64'(p.ax2) - 64'(p.ax1);  day = 64'(p.ay2) - 64'(p.ay1);
    dbx = 64'(p.bx2) - 64'(p.bx1);  dby = 64'(p.by2) - 64'(p.by1);
    wx  = 64'(p.bx1) - 64'(p.ax1);  wy  = 64'(p.by1) - 64'(p.ay1);
    den = dax * dby - day * dbx;
    r.relation  = REL_POINT;
    r.meet_x    = '0;
    r.meet_y    = '0;
    r.saturated = 1'b0;
    if (den == 0) begin
      side_a = wx * day - wy * dax;
      side_b = wx * dby - wy * dbx;
      r.relation = (side_a == 0 && side_b == 0) ? REL_SAME : REL_PARALLEL;
    end else begin
      clamped = 1'b0;
      num = wx * dby - wy * dbx;
      nx = 128'(p.ax1) * 128'(den) + 128'(dax) * 128'(num);
      ny = 128'(p.ay1) * 128'(den) + 128'(day) * 128'(num);
      r.meet_x    = round_to_fixed(nx, den, clamped);
      r.meet_y    = round_to_fixed(ny, den, clamped);
      r.saturated = clamped;
    end
    return r;
  endfunction

  function automatic logic signed [FIELD_BITS-1:0] any_coord();
    return FIELD_BITS'($urandom);
  endfunction

  function automatic logic signed [FIELD_BITS-1:0] near_coord(input int span);
    return FIELD_BITS'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic add_pair(input int ax1, ay1, ax2, ay2, bx1, by1, bx2, by2);
    line_pair_t p;
    p.ax1 = FIELD_BITS'(ax1); p.ay1 = FIELD_BITS'(ay1);
    p.ax2 = FIELD_BITS'(ax2); p.ay2 = FIELD_BITS'(ay2);
    p.bx1 = FIELD_BITS'(bx1); p.by1 = FIELD_BITS'(by1);
    p.bx2 = FIELD_BITS'(bx2); p.by2 = FIELD_BITS'(by2);
    pending_pairs.push_back(p);
  endtask

  // Builds a random pair of one of several shapes. Most are general lines;
  // the rest are placed so that parallel, coincident, degenerate and nearly
  // parallel cases turn up often rather than by chance.
  task automatic add_random_pair();
    line_pair_t p;
    int kind, k, span;
    kind = $urandom_range(0, 99);
    span = ($urandom_range(0, 1) != 0) ? 32767 : 64;
    p.ax1 = near_coord(span); p.ay1 = near_coord(span);
    p.ax2 = near_coord(span); p.ay2 = near_coord(span);
    p.bx1 = near_coord(span); p.by1 = near_coord(span);
    p.bx2 = near_coord(span); p.by2 = near_coord(span);
    if (kind < 30) begin
      p.ax1 = any_coord(); p.ay1 = any_coord(); p.ax2 = any_coord();
      p.ay2 = any_coord(); p.bx1 = any_coord(); p.by1 = any_coord();
      p.bx2 = any_coord(); p.by2 = any_coord();
    end else if (kind < 50) begin
      // Line B runs in a multiple of A's direction, possibly through A.
      p.ax1 = near_coord(200); p.ay1 = near_coord(200);
      p.ax2 = p.ax1 + near_coord(20); p.ay2 = p.ay1 + near_coord(20);
      k = int'($urandom_range(0, 6)) - 3;
      if ($urandom_range(0, 1) != 0) begin
        p.bx1 = FIELD_BITS'(p.ax1 + k * (p.ax2 - p.ax1));
        p.by1 = FIELD_BITS'(p.ay1 + k * (p.ay2 - p.ay1));
      end else begin
        p.bx1 = near_coord(200); p.by1 = near_coord(200);
      end
      k = int'($urandom_range(0, 6)) - 3;
      p.bx2 = FIELD_BITS'(p.bx1 + k * (p.ax2 - p.ax1));
      p.by2 = FIELD_BITS'(p.by1 + k * (p.ay2 - p.ay1));
    end else if (kind < 58) begin
      // One or both lines collapse to a single point.
      p.ax2 = p.ax1; p.ay2 = p.ay1;
      if ($urandom_range(0, 1) != 0) begin
        p.bx2 = p.bx1; p.by2 = p.by1;
      end
    end else if (kind < 68) begin
      // Long, nearly parallel lines drive the point far out.
      p.ax1 = near_coord(32767); p.ay1 = near_coord(32767);
      p.ax2 = -p.ax1;            p.ay2 = -p.ay1;
      p.bx1 = p.ax1 + near_coord(2); p.by1 = p.ay1 + near_coord(2);
      p.bx2 = p.ax2 + near_coord(2); p.by2 = p.ay2 + near_coord(2);
    end
    pending_pairs.push_back(p);
  endtask

  // Stimulus: a short directed set, then random pairs, then the drain.
  initial begin
    add_pair(0, 0, 1, 1, 0, 1, 1, 0);                     // cross at a half
    add_pair(0, 0, 2, 0, 0, 1, 2, 1);                     // parallel, apart
    add_pair(0, 0, 2, 2, 5, 5, 7, 7);                     // one shared line
    add_pair(3, 4, 3, 4, 3, 4, 3, 4);                     // both single points
    add_pair(3, 4, 3, 4, 9, 1, 9, 1);                     // two distinct points
    add_pair(1, 1, 1, 1, 0, 0, 5, 5);                     // point on line B
    add_pair(1, 2, 1, 2, 0, 0, 5, 5);                     // point off line B
    add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    add_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
    add_pair(-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767);
    add_pair(32767, 32767, -32768, -32767, 32767, 32766, -32768, -32768);
    add_pair(-32768, 0, 32767, 1, -32768, 1, 32767, 1);
    add_pair(0, -32768, 1, 32767, 1, -32768, 1, 32767);
    add_pair(0, 0, 0, 1, 0, 0, 1, 0);                     // vertical and horizontal
    add_pair(-1, -1, -1, 5, -7, 2, 4, 2);
    add_pair(0, 0, 3, 1, 0, 1, 3, 0);                     // cross at (1.5, 0.5)
    add_pair(0, 0, 3, 2, 1, 0, -2, 1);
    add_pair(-5, 0, -2, 1, -5, 1, -2, 0);
    add_pair(32767, 32767, 32767, -32768, -32768, 32767, -32768, -32768);
    add_pair(-1, -1, -1, -1, -1, -1, -1, -1);
    while (pending_pairs.size() < TOTAL_PAIRS) add_random_pair();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_pairs.size() == 0 && !in_valid);
    wait (expected_meetings.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    stimulus_done = 1'b1;
    if (!failed && expected_meetings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Driver. A new pair is offered only after the previous transfer, so the
  // payload stays put while the block stalls. The idle rate follows the phase.
  always @(posedge clk) begin
    line_pair_t p;
    int idle_pct;
    idle_pct = pairs_sent < PHASE_LEN ? 8 : (pairs_sent < 2 * PHASE_LEN ? 54 : 0);
    if (rst_n && in_valid && !in_stall) begin
      pairs_sent = pairs_sent + 1;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        p = pending_pairs.pop_front();
        in_ax_first  <= p.ax1;  in_ay_first  <= p.ay1;
        in_ax_second <= p.ax2;  in_ay_second <= p.ay2;
        in_bx_first  <= p.bx1;  in_by_first  <= p.by1;
        in_bx_second <= p.bx2;  in_by_second <= p.by2;
        expected_meetings.push_back(predict_meeting(p));
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The result side stalls at the opposite rate of the sender in each phase.
  always @(posedge clk) begin
    int stall_pct;
    stall_pct = pairs_sent < PHASE_LEN ? 54 : (pairs_sent < 2 * PHASE_LEN ? 8 : 0);
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: every transfer on the result channel is matched against the
  // oldest waiting expectation, field by field.
  always @(posedge clk) begin
    meeting_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_meetings.size() == 0) begin
        $display("%0t: unexpected result relation %0d", $time, out_relation);
        failed = 1'b1;
      end else begin
        e = expected_meetings.pop_front();
        if (out_relation !== e.relation) begin
          $display("%0t: relation expected %0d actual %0d", $time, e.relation,
                   out_relation);
          failed = 1'b1;
        end
        if (out_meet_x !== e.meet_x) begin
          $display("%0t: meet_x expected %0d actual %0d", $time, e.meet_x,
                   out_meet_x);
          failed = 1'b1;
        end
        if (out_meet_y !== e.meet_y) begin
          $display("%0t: meet_y expected %0d actual %0d", $time, e.meet_y,
                   out_meet_y);
          failed = 1'b1;
        end
        if (out_saturated !== e.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time, e.saturated,
                   out_saturated);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on either channel means
  // the block has hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || stimulus_done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
